### rtl/mtrr_pkg.sv
// Package with the types, codes and constants of the member table block.
`timescale 1ns / 1ps
package mtrr_pkg;

   localparam int MAX_MEMBERS = 16;
   localparam int IDX_W       = $clog2(MAX_MEMBERS);
   localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
   localparam int ID_W        = 16;
   localparam int KEY_W       = 64;
   localparam int BIT_CNT_W   = $clog2(KEY_W);

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_NEXT   = 2'd2,
      KIND_HASH   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_PRESENT   = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LOOK_RD,
      S_LOOK_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DIV,
      S_DIV_RD,
      S_SEL_CAP,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_IDX_NEXT,
      RD_RR,
      RD_REM
   } rd_sel_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [ID_W-1:0]  node_id;
      logic [KEY_W-1:0] hash_key;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [ID_W-1:0]  chosen_id;
      logic [4:0]       member_count;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic       status_wr;
      status_type status_code;
      logic       idx_inc;
      logic       append;
      logic       dec_total;
      logic       shift_wr;
      logic       rr_pick;
      logic       div_step;
      logic       cap_chosen;
      logic       load_rsp;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     total_zero;
      logic     full;
      logic     idx_at_end;
      logic     shift_last;
      logic     match;
      logic     div_last;
   } sts_type;

endpackage

### rtl/mtrr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mtrr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mtrr_ctrl.sv
// Controller state machine that sequences search, shift, divide and result steps.
`timescale 1ns / 1ps
module mtrr_ctrl
   import mtrr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = RD_IDX;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (sts.kind == KIND_ADD || sts.kind == KIND_REMOVE) begin
               state_in = S_LOOK_RD;
            end else if (sts.total_zero) begin
               cmd.status_wr   = 1'b1;
               cmd.status_code = STATUS_EMPTY;
               state_in        = S_FINISH;
            end else if (sts.kind == KIND_NEXT) begin
               cmd.rd_sel  = RD_RR;
               cmd.rr_pick = 1'b1;
               state_in    = S_SEL_CAP;
            end else begin
               state_in = S_DIV;
            end
         end
         S_LOOK_RD: begin
            if (sts.idx_at_end) begin
               if (sts.kind == KIND_ADD) begin
                  if (sts.full) begin
                     cmd.status_wr   = 1'b1;
                     cmd.status_code = STATUS_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end else begin
                  cmd.status_wr   = 1'b1;
                  cmd.status_code = STATUS_NOT_FOUND;
               end
               state_in = S_FINISH;
            end else begin
               cmd.rd_sel = RD_IDX;
               state_in   = S_LOOK_CMP;
            end
         end
         S_LOOK_CMP: begin
            if (sts.match) begin
               if (sts.kind == KIND_ADD) begin
                  cmd.status_wr   = 1'b1;
                  cmd.status_code = STATUS_PRESENT;
                  state_in        = S_FINISH;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_LOOK_RD;
            end
         end
         S_SHIFT_RD: begin
            if (sts.shift_last) begin
               cmd.dec_total = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.rd_sel = RD_IDX_NEXT;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DIV_RD;
            end
         end
         S_DIV_RD: begin
            cmd.rd_sel = RD_REM;
            state_in   = S_SEL_CAP;
         end
         S_SEL_CAP: begin
            cmd.cap_chosen = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/mtrr_dp.sv
// Datapath with the member table RAM, counters, pointer, remainder unit and result register.
`timescale 1ns / 1ps
module mtrr_dp
   import mtrr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MEMBERS);

   kind_type             kind_ff;
   logic [ID_W-1:0]      id_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [BIT_CNT_W-1:0] bit_cnt_ff;
   logic [CNT_W-1:0]     total_ff;
   logic [CNT_W-1:0]     rr_ff;
   status_type           status_ff;
   logic [ID_W-1:0]      chosen_ff;
   rsp_type              rsp_ff;

   logic [CNT_W-1:0]     idx_next;
   logic [CNT_W-1:0]     rr_sel;
   logic [CNT_W:0]       trial;
   logic [CNT_W:0]       rem_in;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ID_W-1:0]      wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [ID_W-1:0]      rd_data;

   assign idx_next = idx_ff + CNT_W'(1);
   assign rr_sel   = (rr_ff >= total_ff) ? '0 : rr_ff;
   assign trial    = {rem_ff, key_ff[KEY_W-1]};
   assign rem_in   = (trial >= {1'b0, total_ff}) ? (trial - {1'b0, total_ff}) : trial;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:      rd_addr = idx_ff[IDX_W-1:0];
         RD_IDX_NEXT: rd_addr = idx_next[IDX_W-1:0];
         RD_RR:       rd_addr = rr_sel[IDX_W-1:0];
         RD_REM:      rd_addr = rem_ff[IDX_W-1:0];
         default:     rd_addr = idx_ff[IDX_W-1:0];
      endcase
   end

   assign wr_en   = cmd.append | cmd.shift_wr;
   assign wr_addr = cmd.append ? total_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.append ? id_ff : rd_data;

   mtrr_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_MEMBERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         rr_ff    <= '0;
      end else begin
         if (cmd.append) begin
            total_ff <= total_ff + CNT_W'(1);
         end else if (cmd.dec_total) begin
            total_ff <= total_ff - CNT_W'(1);
         end
         if (cmd.rr_pick) begin
            rr_ff <= rr_sel + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff    <= kind_type'(req_data.kind);
         id_ff      <= req_data.node_id;
         key_ff     <= req_data.hash_key;
         idx_ff     <= '0;
         rem_ff     <= '0;
         bit_cnt_ff <= '0;
         status_ff  <= STATUS_OK;
         chosen_ff  <= '0;
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_next;
         end
         if (cmd.div_step) begin
            rem_ff     <= rem_in[CNT_W-1:0];
            key_ff     <= {key_ff[KEY_W-2:0], 1'b0};
            bit_cnt_ff <= bit_cnt_ff + BIT_CNT_W'(1);
         end
         if (cmd.status_wr) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.cap_chosen) begin
            chosen_ff <= rd_data;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.chosen_id    <= chosen_ff;
         rsp_ff.member_count <= 5'(total_ff);
      end
   end

   assign sts.kind       = kind_ff;
   assign sts.total_zero = (total_ff == '0);
   assign sts.full       = (total_ff >= CNT_MAX);
   assign sts.idx_at_end = (idx_ff >= total_ff);
   assign sts.shift_last = ({1'b0, idx_ff} + (CNT_W + 1)'(1)) >= {1'b0, total_ff};
   assign sts.match      = (rd_data == id_ff);
   assign sts.div_last   = (bit_cnt_ff == BIT_CNT_W'(KEY_W - 1));

   assign rsp_data = rsp_ff;

endmodule

### rtl/member_table_round_robin_hash_select.sv
// Top level of the member table with round-robin and hash selection.
// Add and remove search the table entry by entry; an add that finds its id stops there.
// Remove then moves each later entry down one place. Hash takes the remainder of the key divided by the member count.
// Next or hash on an empty table returns the empty status; a result still waiting at the output delays these.
// A new item is taken only once the result of the last one is loaded into the output register.
// Reset empties the table and clears the round-robin pointer; the RAM itself is not cleared.
`timescale 1ns / 1ps
module member_table_round_robin_hash_select
   import mtrr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   mtrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   mtrr_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

### rtl/mtrr_chk.sv
// Port-level checker for the member table block and its bind to the top level.
`timescale 1ns / 1ps
module mtrr_chk
   import mtrr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam logic [4:0] COUNT_MAX = 5'(MAX_MEMBERS);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |->
         rsp_data.chosen_id == '0 && rsp_data.member_count == '0)
      else $error("empty result with members or a chosen id");

   a_no_choice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_PRESENT ||
                    rsp_data.status == STATUS_NOT_FOUND ||
                    rsp_data.status == STATUS_FULL) |-> rsp_data.chosen_id == '0)
      else $error("chosen id set on an add or remove failure");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |-> rsp_data.member_count == COUNT_MAX)
      else $error("full status while the table has room");

endmodule

bind member_table_round_robin_hash_select mtrr_chk u_mtrr_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
